// ----- src/drgs_pkg.sv -----
package drgs_pkg;

  // Fixed-point layout of the tracker.
  localparam int POS_INT_BITS    = 36;
  localparam int POS_FRAC_BITS   = 16;
  localparam int ANGLE_FRAC_BITS = 24;
  localparam int CORDIC_STEPS    = 24;

  // Field widths.
  localparam int ACT_W  = 3;
  localparam int DT_W   = 22;
  localparam int QUAT_W = 16;
  localparam int SPD_W  = 16;
  localparam int STAT_W = 8;
  localparam int FIX_W  = 36;
  localparam int ANG_W  = 27;
  localparam int DEG_W  = 26;
  localparam int POS_W  = POS_INT_BITS + POS_FRAC_BITS;

  // Configuration port.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 22;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_STEP  = 1'd1;
  localparam logic [STAT_W-1:0]    THRESHOLD_RESET   = 8'd72;
  localparam logic [DT_W-1:0]      MAX_STEP_RESET    = 22'd1000000;

  // Event codes.
  localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ORIENT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SPEED  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_STATUS = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FIX    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_HEAD   = 3'd5;

  // Result kinds.
  localparam logic KIND_POSE    = 1'b0;
  localparam logic KIND_HEADING = 1'b1;

  // CORDIC datapath: x/y hold quaternion terms scaled by 2^20 plus gain.
  localparam int CW   = 58;
  localparam int ZW   = 34;
  localparam int CI_W = 5;
  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] KINV_Q30    = 58'sd652032874;

  // Degree conversion: 180e5/pi in Q8.
  localparam logic [30:0] DEG_E5_Q8  = 31'd1466771956;
  localparam logic [26:0] DEG_E5_MAX = 27'd18000000;
  localparam int DEG_SH = ANGLE_FRAC_BITS + 8;

  // Distance divider: numerator speed*dt scaled by the position fraction.
  localparam int DIV_N_W = 56;
  localparam int DIV_R_W = 17;
  localparam int DIST_W  = 40;
  localparam logic [DIV_R_W:0] DIV_D = 18'd36000;

  // Shared multiplier operand width.
  localparam int MUL_W = 33;

  typedef struct packed {
    logic start;
    logic vec;
  } cordic_ctl_t;

  // Arctangent of 2^-i in Q30.
  function automatic logic [30:0] atan_q30(input logic [CI_W-1:0] i);
    logic [30:0] v;
    case (i)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd31: v = 31'd0;
      default: v = 31'd1 << (5'd30 - i);
    endcase
    return v;
  endfunction

endpackage

// ----- src/drgs_in_if.sv -----
interface drgs_in_if;
  import drgs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [DT_W-1:0]          elapsed_us;
  logic signed [QUAT_W-1:0] quat_w;
  logic signed [QUAT_W-1:0] quat_x;
  logic signed [QUAT_W-1:0] quat_y;
  logic signed [QUAT_W-1:0] quat_z;
  logic [SPD_W-1:0]         speed_raw;
  logic [STAT_W-1:0]        status_flags;
  logic signed [FIX_W-1:0]  fix_x_mm;
  logic signed [FIX_W-1:0]  fix_y_mm;

  modport source (output valid, action, elapsed_us, quat_w, quat_x, quat_y, quat_z,
                  speed_raw, status_flags, fix_x_mm, fix_y_mm, input ready);
  modport sink (input valid, action, elapsed_us, quat_w, quat_x, quat_y, quat_z,
                speed_raw, status_flags, fix_x_mm, fix_y_mm, output ready);
endinterface

// ----- src/drgs_out_if.sv -----
interface drgs_out_if;
  import drgs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    result_kind;
  logic signed [FIX_W-1:0] pos_x_mm;
  logic signed [FIX_W-1:0] pos_y_mm;
  logic signed [ANG_W-1:0] heading_rad;
  logic signed [DEG_W-1:0] heading_deg_e5;

  modport source (output valid, result_kind, pos_x_mm, pos_y_mm, heading_rad,
                  heading_deg_e5, input ready);
  modport sink (input valid, result_kind, pos_x_mm, pos_y_mm, heading_rad,
                heading_deg_e5, output ready);
endinterface

// ----- src/drgs_cordic.sv -----
module drgs_cordic (
  input  logic                         clk,
  input  logic                         rst_n,
  input  drgs_pkg::cordic_ctl_t        ctl,
  input  logic signed [drgs_pkg::CW-1:0] x_in,
  input  logic signed [drgs_pkg::CW-1:0] y_in,
  input  logic signed [drgs_pkg::ZW-1:0] z_in,
  output logic                         done,
  output logic signed [drgs_pkg::CW-1:0] x_out,
  output logic signed [drgs_pkg::CW-1:0] y_out,
  output logic signed [drgs_pkg::ZW-1:0] z_out
);
  import drgs_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [CI_W-1:0]      cnt_r;
  logic                 vec_r;
  logic                 flip_r;
  logic                 zero_r;
  logic signed [CW-1:0] x_r;
  logic signed [CW-1:0] y_r;
  logic signed [ZW-1:0] z_r;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] ang;
  logic                 rot_up;

  // One micro-rotation per cycle.
  assign dx     = x_r >>> cnt_r;
  assign dy     = y_r >>> cnt_r;
  assign ang    = $signed(ZW'(atan_q30(cnt_r)));
  assign rot_up = vec_r ? (y_r > 0) : (z_r < 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        vec_r  <= ctl.vec;
        flip_r <= 1'b0;
        zero_r <= (x_in == 0) && (y_in == 0);
        if (ctl.vec) begin
          // Fold the left half plane onto the right one.
          if (x_in < 0) begin
            if (y_in >= 0) begin
              x_r <= y_in;
              y_r <= -x_in;
              z_r <= HALF_PI_Q30;
            end else begin
              x_r <= -y_in;
              y_r <= x_in;
              z_r <= -HALF_PI_Q30;
            end
          end else begin
            x_r <= x_in;
            y_r <= y_in;
            z_r <= '0;
          end
        end else begin
          // Bring the angle into the right half plane.
          x_r <= KINV_Q30;
          y_r <= '0;
          if (z_in > HALF_PI_Q30) begin
            z_r    <= z_in - PI_Q30;
            flip_r <= 1'b1;
          end else if (z_in < -HALF_PI_Q30) begin
            z_r    <= z_in + PI_Q30;
            flip_r <= 1'b1;
          end else begin
            z_r <= z_in;
          end
        end
      end else if (busy_r) begin
        if (rot_up) begin
          x_r <= x_r + dy;
          y_r <= y_r - dx;
          z_r <= z_r + ang;
        end else begin
          x_r <= x_r - dy;
          y_r <= y_r + dx;
          z_r <= z_r - ang;
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CI_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Final sign fix and angle clamp.
  always_comb begin
    x_out = (!vec_r && flip_r) ? -x_r : x_r;
    y_out = (!vec_r && flip_r) ? -y_r : y_r;
    if (zero_r) begin
      z_out = '0;
    end else if (z_r > PI_Q30) begin
      z_out = PI_Q30;
    end else if (z_r < -PI_Q30) begin
      z_out = -PI_Q30;
    end else begin
      z_out = z_r;
    end
  end

  assign done = done_r;

endmodule

// ----- src/drgs_div.sv -----
module drgs_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [drgs_pkg::DIV_N_W-1:0]    num_in,
  output logic                            done,
  output logic [drgs_pkg::DIST_W-1:0]     quot
);
  import drgs_pkg::*;

  // Long division by 36000 in radix 2^16. Since 36000 = 32 * 1125, each digit
  // drops five bits and multiplies by a rounded-up reciprocal of 1125, which is
  // exact for every 27-bit partial dividend.
  localparam int DIG_W  = 16;
  localparam int PAD_W  = 64;
  localparam int T_W    = 2 * DIG_W;
  localparam int TS_W   = T_W - 5;
  localparam int RCP_W  = 28;
  localparam int RCP_SH = 38;
  localparam int PRD_W  = TS_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP   = 28'd244335918;
  localparam logic [DIG_W-1:0] DIVISOR = DIV_D[DIG_W-1:0];

  logic                busy_r;
  logic                done_r;
  logic                phase_r;
  logic [1:0]          cnt_r;
  logic [PAD_W-1:0]    num_r;
  logic [DIG_W-1:0]    rem_r;
  logic [T_W-1:0]      t_r;
  logic [DIG_W-1:0]    dig_r;
  logic [DIST_W-1:0]   q_r;

  logic [T_W-1:0]      t_cur;
  logic [PRD_W-1:0]    est;
  logic [T_W-1:0]      back;

  // Partial dividend, digit estimate and the amount it takes away.
  assign t_cur = {rem_r, num_r[PAD_W-1 -: DIG_W]};
  assign est   = PRD_W'(t_cur[T_W-1:5]) * PRD_W'(RECIP);
  assign back  = T_W'(dig_r) * T_W'(DIVISOR);

  // Each digit in two steps: estimate the digit, then form the remainder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 1'b0;
        cnt_r   <= '0;
        num_r   <= PAD_W'(num_in);
        rem_r   <= '0;
        q_r     <= '0;
      end else if (busy_r) begin
        if (!phase_r) begin
          t_r     <= t_cur;
          dig_r   <= est[RCP_SH +: DIG_W];
          phase_r <= 1'b1;
        end else begin
          rem_r   <= DIG_W'(t_r - back);
          q_r     <= {q_r[DIST_W-DIG_W-1:0], dig_r};
          num_r   <= {num_r[PAD_W-DIG_W-1:0], {DIG_W{1'b0}}};
          phase_r <= 1'b0;
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == 2'd3) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- src/dead_reckoning_gps_snap.sv -----
// Dead-reckoning pose tracker with GNSS snap, one event at a time.
// Speed, status and fix events finish in the idle state; a heading request
// runs the degree conversion. An orientation event runs 8 products and 24
// CORDIC steps; a tick runs the distance divide, CORDIC and step products.
// Synchronous active-low reset clears the pose, held inputs and handshakes
// and loads the register defaults.
module dead_reckoning_gps_snap (
  input  logic                            clk,
  input  logic                            rst_n,
  drgs_in_if.sink                         in_ch,
  drgs_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [drgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drgs_pkg::CFG_W-1:0]      cfg_wdata
);
  import drgs_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_QMUL   = 4'd1;
  localparam logic [3:0] S_QSUM   = 4'd2;
  localparam logic [3:0] S_ATAN   = 4'd3;
  localparam logic [3:0] S_SPD    = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_SINCOS = 4'd6;
  localparam logic [3:0] S_MX0    = 4'd7;
  localparam logic [3:0] S_MX1    = 4'd8;
  localparam logic [3:0] S_MY0    = 4'd9;
  localparam logic [3:0] S_MY1    = 4'd10;
  localparam logic [3:0] S_UPD    = 4'd11;
  localparam logic [3:0] S_DEG    = 4'd12;
  localparam logic [3:0] S_EMIT   = 4'd13;

  localparam int QS_W   = 35;
  localparam int ACC_W  = 52;
  localparam int RX_W   = ACC_W - 10;
  localparam int SUM_W  = POS_W + 1;
  localparam int ANG_SH = 30 - ANGLE_FRAC_BITS;
  localparam int PROD_W = SPD_W + DT_W;

  // Control and configuration.
  logic [3:0]        state_r;
  logic [2:0]        cnt_r;
  logic [STAT_W-1:0] thr_r;
  logic [DT_W-1:0]   max_step_r;

  // Tracker state.
  logic signed [POS_W-1:0] pos_x_r;
  logic signed [POS_W-1:0] pos_y_r;
  logic signed [ANG_W-1:0] head_est_r;
  logic signed [ANG_W-1:0] head_imu_r;
  logic [SPD_W-1:0]        speed_r;
  logic                    fix_good_r;

  // Working registers.
  logic signed [QUAT_W-1:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [31:0]       p_r [8];
  logic                     gimbal_r;
  logic [DT_W-1:0]          dt_r;
  logic [DIST_W-1:0]        dist_r;
  logic [31:0]              cabs_r, sabs_r;
  logic                     cneg_r, sneg_r;
  logic [ACC_W-1:0]         accx_r, accy_r;
  logic                     kind_r;
  logic signed [DEG_W-1:0]  deg_r;

  // Shared unit handshakes.
  logic                     cstart_r, cvec_r;
  logic signed [CW-1:0]     cx_r, cy_r;
  logic signed [ZW-1:0]     cz_r;
  logic                     dstart_r;
  logic [DIV_N_W-1:0]       dnum_r;
  cordic_ctl_t              cctl;
  logic                     cdone, ddone;
  logic signed [CW-1:0]     cx_o, cy_o;
  logic signed [ZW-1:0]     cz_o;
  logic [DIST_W-1:0]        dquot;

  // Output register.
  logic                     out_valid_r;
  logic                     out_kind_r;
  logic signed [FIX_W-1:0]  out_x_r, out_y_r;
  logic signed [ANG_W-1:0]  out_head_r;
  logic signed [DEG_W-1:0]  out_deg_r;

  // Combinational helpers.
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [2*MUL_W-1:0]  mul_p;
  logic signed [QS_W-1:0]     qd, qm20, qnum, qden, qm20_abs;
  logic signed [ZW-1:0]       yaw_q;
  logic [RX_W-1:0]            rx, ry;
  logic signed [SUM_W-1:0]    sum_x, sum_y;
  logic [ANG_W-1:0]           habs;
  logic [ANG_W-1:0]           deg_q, deg_c;
  logic                       out_free;

  assign cctl = '{start: cstart_r, vec: cvec_r};

  drgs_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cctl),
    .x_in  (cx_r),
    .y_in  (cy_r),
    .z_in  (cz_r),
    .done  (cdone),
    .x_out (cx_o),
    .y_out (cy_o),
    .z_out (cz_o)
  );

  drgs_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (dstart_r),
    .num_in (dnum_r),
    .done   (ddone),
    .quot   (dquot)
  );

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_QMUL: begin
        case (cnt_r)
          3'd0: begin mul_a = MUL_W'(qw_r); mul_b = MUL_W'(qw_r); end
          3'd1: begin mul_a = MUL_W'(qx_r); mul_b = MUL_W'(qx_r); end
          3'd2: begin mul_a = MUL_W'(qy_r); mul_b = MUL_W'(qy_r); end
          3'd3: begin mul_a = MUL_W'(qz_r); mul_b = MUL_W'(qz_r); end
          3'd4: begin mul_a = MUL_W'(qx_r); mul_b = MUL_W'(qz_r); end
          3'd5: begin mul_a = MUL_W'(qw_r); mul_b = MUL_W'(qy_r); end
          3'd6: begin mul_a = MUL_W'(qx_r); mul_b = MUL_W'(qy_r); end
          default: begin mul_a = MUL_W'(qw_r); mul_b = MUL_W'(qz_r); end
        endcase
      end
      S_SPD: begin
        mul_a = $signed({17'b0, speed_r});
        mul_b = $signed({11'b0, dt_r});
      end
      S_MX0: begin
        mul_a = $signed({13'b0, dist_r[39:20]});
        mul_b = $signed({1'b0, cabs_r});
      end
      S_MX1: begin
        mul_a = $signed({13'b0, dist_r[19:0]});
        mul_b = $signed({1'b0, cabs_r});
      end
      S_MY0: begin
        mul_a = $signed({13'b0, dist_r[39:20]});
        mul_b = $signed({1'b0, sabs_r});
      end
      S_MY1: begin
        mul_a = $signed({13'b0, dist_r[19:0]});
        mul_b = $signed({1'b0, sabs_r});
      end
      S_DEG: begin
        mul_a = $signed({6'b0, habs});
        mul_b = $signed({2'b0, DEG_E5_Q8});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Quaternion sums: norm, gimbal term, yaw numerator and denominator.
  always_comb begin
    qd   = QS_W'(p_r[0]) + QS_W'(p_r[1]) + QS_W'(p_r[2]) + QS_W'(p_r[3]);
    qm20 = (QS_W'(p_r[4]) - QS_W'(p_r[5])) <<< 1;
    qnum = (QS_W'(p_r[6]) + QS_W'(p_r[7])) <<< 1;
    qden = QS_W'(p_r[0]) + QS_W'(p_r[1]) - QS_W'(p_r[2]) - QS_W'(p_r[3]);
    qm20_abs = (qm20 < 0) ? -qm20 : qm20;
  end

  // Angle rounding, step rounding, saturating sums and degree clamp.
  assign yaw_q = (cz_o + ZW'(1 << (ANG_SH - 1))) >>> ANG_SH;
  assign rx    = RX_W'((accx_r + ACC_W'(512)) >> 10);
  assign ry    = RX_W'((accy_r + ACC_W'(512)) >> 10);
  assign sum_x = SUM_W'(pos_x_r) + (cneg_r ? -$signed(SUM_W'(rx)) : $signed(SUM_W'(rx)));
  assign sum_y = SUM_W'(pos_y_r) + (sneg_r ? -$signed(SUM_W'(ry)) : $signed(SUM_W'(ry)));
  assign habs  = (head_est_r < 0) ? ANG_W'(-head_est_r) : ANG_W'(head_est_r);
  assign deg_q = mul_p[DEG_SH+ANG_W-1:DEG_SH];
  assign deg_c = (deg_q > DEG_E5_MAX) ? DEG_E5_MAX : deg_q;
  assign out_free = !out_valid_r || out_ch.ready;

  function automatic logic signed [POS_W-1:0] pos_sat(input logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v[SUM_W-1] != v[SUM_W-2]) begin
      r = v[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // Sequencer and state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= THRESHOLD_RESET;
      max_step_r  <= MAX_STEP_RESET;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      head_est_r  <= '0;
      head_imu_r  <= '0;
      speed_r     <= '0;
      fix_good_r  <= 1'b0;
      cstart_r    <= 1'b0;
      dstart_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cstart_r <= 1'b0;
      dstart_r <= 1'b0;

      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // Configuration writes.
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_THRESHOLD: thr_r      <= cfg_wdata[STAT_W-1:0];
          CFG_IDX_MAX_STEP:  max_step_r <= cfg_wdata[DT_W-1:0];
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            case (in_ch.action)
              ACT_TICK: begin
                if (in_ch.elapsed_us != '0 && in_ch.elapsed_us <= max_step_r) begin
                  dt_r    <= in_ch.elapsed_us;
                  state_r <= S_SPD;
                end
              end
              ACT_ORIENT: begin
                qw_r    <= in_ch.quat_w;
                qx_r    <= in_ch.quat_x;
                qy_r    <= in_ch.quat_y;
                qz_r    <= in_ch.quat_z;
                cnt_r   <= '0;
                state_r <= S_QMUL;
              end
              ACT_SPEED: speed_r <= in_ch.speed_raw;
              ACT_STATUS: fix_good_r <= (in_ch.status_flags >= thr_r);
              ACT_FIX: begin
                if (fix_good_r) begin
                  pos_x_r    <= {in_ch.fix_x_mm, {POS_FRAC_BITS{1'b0}}};
                  pos_y_r    <= {in_ch.fix_y_mm, {POS_FRAC_BITS{1'b0}}};
                  head_est_r <= head_imu_r;
                end
              end
              ACT_HEAD: begin
                if (fix_good_r) begin
                  kind_r  <= KIND_HEADING;
                  state_r <= S_DEG;
                end
              end
              default: ;
            endcase
          end
        end

        // Eight quaternion products through the shared multiplier.
        S_QMUL: begin
          p_r[cnt_r] <= mul_p[31:0];
          cnt_r      <= cnt_r + 1'b1;
          if (cnt_r == 3'd7) begin
            state_r <= S_QSUM;
          end
        end

        S_QSUM: begin
          gimbal_r <= (qd > 0) && (qm20_abs >= qd);
          cx_r     <= CW'(qden) <<< 20;
          cy_r     <= CW'(qnum) <<< 20;
          cz_r     <= '0;
          cvec_r   <= 1'b1;
          cstart_r <= 1'b1;
          state_r  <= S_ATAN;
        end

        S_ATAN: begin
          if (cdone) begin
            head_imu_r <= gimbal_r ? '0 : yaw_q[ANG_W-1:0];
            state_r    <= S_IDLE;
          end
        end

        // Distance: round(speed*dt*2^frac / 36000).
        S_SPD: begin
          dnum_r   <= (DIV_N_W'(mul_p[PROD_W-1:0]) << POS_FRAC_BITS)
                      + DIV_N_W'(DIV_D >> 1);
          dstart_r <= 1'b1;
          state_r  <= S_DIV;
        end

        S_DIV: begin
          if (ddone) begin
            dist_r   <= dquot;
            cx_r     <= '0;
            cy_r     <= '0;
            cz_r     <= ZW'(head_est_r) <<< ANG_SH;
            cvec_r   <= 1'b0;
            cstart_r <= 1'b1;
            state_r  <= S_SINCOS;
          end
        end

        S_SINCOS: begin
          if (cdone) begin
            cneg_r  <= (cx_o < 0);
            sneg_r  <= (cy_o < 0);
            cabs_r  <= (cx_o < 0) ? 32'(-cx_o) : 32'(cx_o);
            sabs_r  <= (cy_o < 0) ? 32'(-cy_o) : 32'(cy_o);
            state_r <= S_MX0;
          end
        end

        // Step products: high part whole, low part after dropping 20 bits.
        S_MX0: begin
          accx_r  <= mul_p[ACC_W-1:0];
          state_r <= S_MX1;
        end
        S_MX1: begin
          accx_r  <= accx_r + ACC_W'(mul_p[51:20]);
          state_r <= S_MY0;
        end
        S_MY0: begin
          accy_r  <= mul_p[ACC_W-1:0];
          state_r <= S_MY1;
        end
        S_MY1: begin
          accy_r  <= accy_r + ACC_W'(mul_p[51:20]);
          state_r <= S_UPD;
        end

        S_UPD: begin
          pos_x_r    <= pos_sat(sum_x);
          pos_y_r    <= pos_sat(sum_y);
          head_est_r <= head_imu_r;
          kind_r     <= KIND_POSE;
          state_r    <= S_DEG;
        end

        S_DEG: begin
          deg_r   <= (head_est_r < 0) ? -$signed(deg_c[DEG_W-1:0])
                                      : $signed(deg_c[DEG_W-1:0]);
          state_r <= S_EMIT;
        end

        // Load the output register once the previous result has left.
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= kind_r;
            out_x_r     <= pos_x_r[POS_W-1:POS_FRAC_BITS];
            out_y_r     <= pos_y_r[POS_W-1:POS_FRAC_BITS];
            out_head_r  <= head_est_r;
            out_deg_r   <= deg_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_kind    = out_kind_r;
  assign out_ch.pos_x_mm       = out_x_r;
  assign out_ch.pos_y_mm       = out_y_r;
  assign out_ch.heading_rad    = out_head_r;
  assign out_ch.heading_deg_e5 = out_deg_r;

endmodule

// ----- src/drgs_checker.sv -----
module drgs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [drgs_pkg::ACT_W-1:0]       in_action,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_kind,
  input logic signed [drgs_pkg::FIX_W-1:0] out_x,
  input logic signed [drgs_pkg::FIX_W-1:0] out_y,
  input logic signed [drgs_pkg::ANG_W-1:0] out_head,
  input logic signed [drgs_pkg::DEG_W-1:0] out_deg
);
  import drgs_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_x) && $stable(out_y)
      && $stable(out_head) && $stable(out_deg))
    else $error("result payload changed while stalled");

  // Degree output stays within half a turn.
  a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_deg <= 26'sd18000000) && (out_deg >= -26'sd18000000))
    else $error("heading in degrees out of range");

  // Degrees and radians agree in sign.
  a_deg_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_deg == 0) || ((out_deg < 0) == (out_head < 0)))
    else $error("heading sign mismatch");

  // An orientation transfer keeps the block busy in the next cycle.
  a_orient_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_ORIENT) |=> !in_ready)
    else $error("ready during orientation work");

endmodule

bind dead_reckoning_gps_snap drgs_checker u_drgs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.result_kind),
  .out_x     (out_ch.pos_x_mm),
  .out_y     (out_ch.pos_y_mm),
  .out_head  (out_ch.heading_rad),
  .out_deg   (out_ch.heading_deg_e5)
);

// ----- tb/sv/dead_reckoning_gps_snap_test.sv -----
`timescale 1ns / 100ps

module dead_reckoning_gps_snap_test;
  import drgs_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 160;

  typedef struct {
    logic [ACT_W-1:0]         action;
    logic [DT_W-1:0]          dt;
    logic signed [QUAT_W-1:0] qw, qx, qy, qz;
    logic [SPD_W-1:0]         spd;
    logic [STAT_W-1:0]        stat;
    logic signed [FIX_W-1:0]  fx, fy;
  } sensor_event_t;

  typedef struct {
    logic                    kind;
    logic signed [FIX_W-1:0] px, py;
    logic signed [ANG_W-1:0] hrad;
    logic signed [DEG_W-1:0] hdeg;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  drgs_in_if in_ch();
  drgs_out_if out_ch();

  dead_reckoning_gps_snap u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Tracker state mirrored by the predictor.
  longint pos_x = 0, pos_y = 0, head_est = 0, head_imu = 0;
  longint unsigned speed_held = 0;
  bit fix_ok = 0;
  longint unsigned ok_threshold = THRESHOLD_RESET;
  longint unsigned max_step = MAX_STEP_RESET;

  pose_t expected_poses[$];
  int errors = 0;
  int sent_items = 0;
  int seen_results = 0;
  int idle_cycles = 0;
  bit no_idle = 0;
  int stall_left = 0;

  longint atan_tab[32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0};

  initial begin
    forever #2 clk = ~clk;
  end

  // Vectoring CORDIC, result in Q30 radians.
  function automatic longint vec_atan2(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI_Q30;
      end else begin
        x = -y; y = t; z = -longint'(HALF_PI_Q30);
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y > 0) begin
        x += dy; y -= dx; z += atan_tab[i];
      end else begin
        x -= dy; y += dx; z -= atan_tab[i];
      end
    end
    if (z > longint'(PI_Q30)) z = PI_Q30;
    if (z < -longint'(PI_Q30)) z = -longint'(PI_Q30);
    return z;
  endfunction

  // Rotating CORDIC giving cosine and sine in Q30.
  function automatic void rot_sincos(longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    bit flip;
    x = KINV_Q30;
    y = 0;
    flip = 0;
    if (z > longint'(HALF_PI_Q30)) begin
      z -= PI_Q30; flip = 1;
    end else if (z < -longint'(HALF_PI_Q30)) begin
      z += PI_Q30; flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (z >= 0) begin
        x -= dy; y += dx; z -= atan_tab[i];
      end else begin
        x += dy; y -= dx; z += atan_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint scale_q30(longint a, longint c);
    bit neg;
    longint unsigned ua, uc, r;
    neg = (a < 0) != (c < 0);
    ua = a < 0 ? -a : a;
    uc = c < 0 ? -c : c;
    r = (ua >> 20) * uc + (((ua & 64'hFFFFF) * uc) >> 20);
    r = (r + 512) >> 10;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp_pos(longint v);
    longint hi;
    hi = (longint'(1) <<< (POS_W - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint heading_to_deg(longint h);
    longint unsigned m;
    longint q;
    m = h < 0 ? -h : h;
    q = longint'((m * longint'(DEG_E5_Q8)) >> DEG_SH);
    if (q > longint'(DEG_E5_MAX)) q = DEG_E5_MAX;
    return h < 0 ? -q : q;
  endfunction

  function automatic longint quat_to_yaw(sensor_event_t e);
    longint w, x, y, z, d, m20, num, den, a;
    w = e.qw; x = e.qx; y = e.qy; z = e.qz;
    d = w * w + x * x + y * y + z * z;
    m20 = 2 * (x * z - w * y);
    num = 2 * (x * y + w * z);
    den = w * w + x * x - y * y - z * z;
    if (m20 < 0) m20 = -m20;
    if (d > 0 && m20 >= d) return 0;
    a = vec_atan2(num <<< 20, den <<< 20);
    return (a + (longint'(1) <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
  endfunction

  // Applies one event to the mirrored state; returns 1 when a result is due.
  function automatic bit track_event(sensor_event_t e, output pose_t p);
    longint unsigned step_mm;
    longint c, s;
    p.kind = KIND_POSE;
    case (e.action)
      ACT_TICK: begin
        if (e.dt == 0 || e.dt > max_step) return 0;
        step_mm = ((speed_held * e.dt << POS_FRAC_BITS) + 18000) / 36000;
        rot_sincos(head_est <<< (30 - ANGLE_FRAC_BITS), c, s);
        pos_x = clamp_pos(pos_x + scale_q30(longint'(step_mm), c));
        pos_y = clamp_pos(pos_y + scale_q30(longint'(step_mm), s));
        head_est = head_imu;
      end
      ACT_ORIENT: begin
        head_imu = quat_to_yaw(e);
        return 0;
      end
      ACT_SPEED: begin
        speed_held = e.spd;
        return 0;
      end
      ACT_STATUS: begin
        fix_ok = e.stat >= ok_threshold;
        return 0;
      end
      ACT_FIX: begin
        if (fix_ok) begin
          pos_x = clamp_pos(longint'(e.fx) <<< POS_FRAC_BITS);
          pos_y = clamp_pos(longint'(e.fy) <<< POS_FRAC_BITS);
          head_est = head_imu;
        end
        return 0;
      end
      ACT_HEAD: begin
        if (!fix_ok) return 0;
        p.kind = KIND_HEADING;
      end
      default: return 0;
    endcase
    p.px = FIX_W'(pos_x >>> POS_FRAC_BITS);
    p.py = FIX_W'(pos_y >>> POS_FRAC_BITS);
    p.hrad = ANG_W'(head_est);
    p.hdeg = DEG_W'(heading_to_deg(head_est));
    return 1;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Event with every field random; the caller fixes the ones that matter.
  function automatic sensor_event_t rand_event(logic [ACT_W-1:0] act);
    sensor_event_t e;
    e.action = act;
    e.dt = DT_W'($urandom);
    e.qw = QUAT_W'($urandom_range(0, 32768) - 16384);
    e.qx = QUAT_W'($urandom_range(0, 32768) - 16384);
    e.qy = QUAT_W'($urandom_range(0, 32768) - 16384);
    e.qz = QUAT_W'($urandom_range(0, 32768) - 16384);
    e.spd = SPD_W'($urandom);
    e.stat = STAT_W'($urandom);
    e.fx = FIX_W'({$urandom, $urandom});
    e.fy = FIX_W'({$urandom, $urandom});
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
             seen_results);
    errors++;
  endtask

  // Sends one event; the prediction is queued at the transfer edge.
  task automatic send_event(sensor_event_t e);
    int gap;
    pose_t p;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.action = e.action;
    in_ch.elapsed_us = e.dt;
    in_ch.quat_w = e.qw;
    in_ch.quat_x = e.qx;
    in_ch.quat_y = e.qy;
    in_ch.quat_z = e.qz;
    in_ch.speed_raw = e.spd;
    in_ch.status_flags = e.stat;
    in_ch.fix_x_mm = e.fx;
    in_ch.fix_y_mm = e.fy;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (track_event(e, p)) expected_poses.push_back(p);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic tick(longint unsigned dt);
    sensor_event_t e;
    e = rand_event(ACT_TICK);
    e.dt = DT_W'(dt);
    send_event(e);
  endtask

  task automatic orient(int w, int x, int y, int z);
    sensor_event_t e;
    e = rand_event(ACT_ORIENT);
    e.qw = QUAT_W'(w); e.qx = QUAT_W'(x); e.qy = QUAT_W'(y); e.qz = QUAT_W'(z);
    send_event(e);
  endtask

  task automatic set_speed(int v);
    sensor_event_t e;
    e = rand_event(ACT_SPEED);
    e.spd = SPD_W'(v);
    send_event(e);
  endtask

  task automatic set_status(int v);
    sensor_event_t e;
    e = rand_event(ACT_STATUS);
    e.stat = STAT_W'(v);
    send_event(e);
  endtask

  task automatic send_fix(longint x, longint y);
    sensor_event_t e;
    e = rand_event(ACT_FIX);
    e.fx = FIX_W'(x); e.fy = FIX_W'(y);
    send_event(e);
  endtask

  task automatic ask_heading();
    send_event(rand_event(ACT_HEAD));
  endtask

  // Register write, only once the block has gone quiet.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned value);
    in_ch.valid = 1'b0;
    while (expected_poses.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_IDX_THRESHOLD) ok_threshold = value & 8'hFF;
    else max_step = value & 22'h3FFFFF;
  endtask

  // Basic operations, bad fix, unused codes and field extremes.
  task automatic test_basic_events();
    no_idle = 1;
    ask_heading();
    send_fix(100, 200);
    set_status(71);
    ask_heading();
    set_status(72);
    send_fix(-36'sd34359738368, 36'sd34359738367);
    ask_heading();
    send_event(rand_event(3'd6));
    send_event(rand_event(3'd7));
    set_speed(65535);
    orient(16384, 0, 0, 0);
    tick(1);
    set_speed(0);
    tick(4194303);
    no_idle = 0;
  endtask

  // Gimbal lock, zero quaternion and extreme yaw angles.
  task automatic test_orientation_cases();
    set_status(255);
    orient(11585, 0, 11585, 0);
    send_fix(0, 0);
    ask_heading();
    orient(0, 0, 0, 0);
    send_fix(0, 0);
    ask_heading();
    orient(0, 0, 0, 16384);
    send_fix(0, 0);
    ask_heading();
    orient(0, 0, 0, -16384);
    send_fix(0, 0);
    ask_heading();
    orient(-16384, -16384, -16384, -16384);
    tick(7);
  endtask

  // Skipped ticks at both ends and position saturation.
  task automatic test_skip_and_saturation();
    set_speed(65535);
    tick(0);
    tick(MAX_STEP_RESET + 1);
    orient(16384, 0, 0, 0);
    send_fix(36'sd34359738367, 0);
    tick(MAX_STEP_RESET);
    tick(MAX_STEP_RESET);
    orient(11585, 0, 0, -11585);
    tick(1000);
    send_fix(0, -36'sd34359738368);
    tick(MAX_STEP_RESET);
    orient(0, 0, 0, 16384);
    tick(1000);
    tick(MAX_STEP_RESET);
    ask_heading();
  endtask

  // Well-formed traffic with random content, plus some noise.
  task automatic random_phase(int count);
    sensor_event_t e;
    int r;
    longint unsigned lim;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      lim = max_step < 20000 ? max_step : 20000;
      if (r < 4) begin
        e = rand_event(ACT_W'($urandom_range(6, 7)));
      end else if (r < 34) begin
        e = rand_event(ACT_TICK);
        r = $urandom_range(0, 19);
        if (r < 16) e.dt = DT_W'($urandom_range(1, lim));
        else if (r == 16) e.dt = 0;
        else if (r == 17) e.dt = DT_W'(max_step);
        else if (r == 18) e.dt = DT_W'(max_step + 1);
      end else if (r < 49) begin
        e = rand_event(ACT_ORIENT);
      end else if (r < 62) begin
        e = rand_event(ACT_SPEED);
      end else if (r < 74) begin
        e = rand_event(ACT_STATUS);
        if ($urandom_range(0, 3) != 0) e.stat = STAT_W'($urandom_range(ok_threshold, 255));
      end else if (r < 85) begin
        e = rand_event(ACT_FIX);
        if ($urandom_range(0, 3) != 0) begin
          e.fx = $signed(36'($urandom_range(0, 33554431))) - 36'sd16777216;
          e.fy = $signed(36'($urandom_range(0, 33554431))) - 36'sd16777216;
        end
      end else begin
        e = rand_event(ACT_HEAD);
      end
      if (n % 60 < 8) no_idle = 1;
      else no_idle = 0;
      send_event(e);
    end
    no_idle = 0;
  endtask

  // Random traffic across several register settings, extremes included.
  task automatic test_register_sweep();
    random_phase(175);
    write_reg(CFG_IDX_THRESHOLD, 0);
    write_reg(CFG_IDX_MAX_STEP, 22'h3FFFFF);
    random_phase(175);
    write_reg(CFG_IDX_THRESHOLD, 255);
    write_reg(CFG_IDX_MAX_STEP, 1);
    random_phase(175);
    write_reg(CFG_IDX_THRESHOLD, $urandom_range(0, 255));
    write_reg(CFG_IDX_MAX_STEP, $urandom_range(1, 4194303));
    random_phase(175);
    write_reg(CFG_IDX_THRESHOLD, 1);
    write_reg(CFG_IDX_MAX_STEP, 5000);
    random_phase(175);
    write_reg(CFG_IDX_THRESHOLD, THRESHOLD_RESET);
    write_reg(CFG_IDX_MAX_STEP, MAX_STEP_RESET);
    random_phase(100);
  endtask

  // Result checker against the oldest prediction.
  always @(posedge clk) begin
    pose_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_results++;
      if (expected_poses.size() == 0) begin
        $display("unexpected result %0d with no prediction pending", seen_results);
        errors++;
      end else begin
        want = expected_poses.pop_front();
        if (out_ch.result_kind !== want.kind)
          report_mismatch("result_kind", out_ch.result_kind, want.kind);
        if (out_ch.pos_x_mm !== want.px) report_mismatch("pos_x_mm", out_ch.pos_x_mm, want.px);
        if (out_ch.pos_y_mm !== want.py) report_mismatch("pos_y_mm", out_ch.pos_y_mm, want.py);
        if (out_ch.heading_rad !== want.hrad)
          report_mismatch("heading_rad", out_ch.heading_rad, want.hrad);
        if (out_ch.heading_deg_e5 !== want.hdeg)
          report_mismatch("heading_deg_e5", out_ch.heading_deg_e5, want.hdeg);
      end
    end
  end

  // Random back-pressure on the result side.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
      if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", expected_poses.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.elapsed_us = '0;
    in_ch.quat_w = '0;
    in_ch.quat_x = '0;
    in_ch.quat_y = '0;
    in_ch.quat_z = '0;
    in_ch.speed_raw = '0;
    in_ch.status_flags = '0;
    in_ch.fix_x_mm = '0;
    in_ch.fix_y_mm = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_basic_events();
    test_orientation_cases();
    test_skip_and_saturation();
    test_register_sweep();
    in_ch.valid = 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d sensor events over six register settings; checked %0d results.",
             sent_items, seen_results);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
src/drgs_pkg.sv
src/drgs_in_if.sv
src/drgs_out_if.sv
src/drgs_cordic.sv
src/drgs_div.sv
src/dead_reckoning_gps_snap.sv
src/drgs_checker.sv
tb/sv/dead_reckoning_gps_snap_test.sv
